FILE: src/pol_pkg.sv
// Package for the positional ordered list: sizes, command and status codes,
// the controller-to-datapath command struct and word conversion helpers.
// No dependencies.
package pol_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CMD_W      = 3;
  localparam int POS_W      = 6;
  localparam int VAL_W      = 32;
  localparam int STS_W      = 3;
  localparam int OCNT_W     = 7;
  localparam int OIDX_W     = 6;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd4;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic start;
    logic load_out;
  } dp_cmd_t;

  function automatic word_t to_word(input logic signed [VAL_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic [VAL_W-1:0] from_word(input word_t w);
    return VAL_W'(signed'(w));
  endfunction

endpackage

FILE: src/pol_ctrl.sv
// Controller for the positional ordered list: idle/execute sequencing and
// the output beat valid. Depends on pol_pkg.
module pol_ctrl import pol_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_stall_o       = (state_q != S_IDLE);
  assign cmd_o.start      = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.load_out   = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o      = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_o.start) state_d = S_EXEC;
      S_EXEC: if (cmd_o.load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> state_q == S_EXEC) else $error("load outside exec");
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load_out)) else $error("valid without load");
  a_exec_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == S_EXEC && !cmd_o.start) else $error("start overlap");

endmodule

FILE: src/pol_dp.sv
// Datapath for the positional ordered list: shifting entry cells, entry
// count, parallel compare, first-match encoder and output registers.
// Depends on pol_pkg.
module pol_dp import pol_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic signed [VAL_W-1:0] data_out_o,
  output logic [OIDX_W-1:0]       found_index_o,
  output logic [STS_W-1:0]        status_o,
  output logic [OCNT_W-1:0]       count_o
);

  word_t              cells_q [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [CMD_W-1:0]   op_q;
  logic [STS_W-1:0]   sts_q, sts_d;
  logic [VAL_W-1:0]   data_q, data_d;

  logic [VAL_W-1:0]   data_out_q;
  logic [OIDX_W-1:0]  found_q;
  logic [STS_W-1:0]   status_q;
  logic [OCNT_W-1:0]  count_out_q;

  word_t              word;
  word_t              rd_word;
  logic [CMP_W-1:0]   pos_c, cnt_c;
  logic               ins_ok, del_ok, rd_ok;
  logic [CAPACITY-1:0] low_bit;
  logic [IDX_W-1:0]   first_idx;
  logic               hit;

  assign word  = to_word(value_i);
  assign pos_c = CMP_W'(position_i);
  assign cnt_c = CMP_W'(count_q);

  always_comb begin
    sts_d  = ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rd_ok  = 1'b0;
    unique case (command_i)
      CMD_INSERT: begin
        if (pos_c > cnt_c) begin
          sts_d = ST_BADPOS;
        end else if (count_q >= CNT_W'(CAPACITY)) begin
          sts_d = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      CMD_DELETE, CMD_GET: begin
        if (count_q == '0) begin
          sts_d = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          sts_d = ST_BADPOS;
        end else begin
          rd_ok  = 1'b1;
          del_ok = (command_i == CMD_DELETE);
        end
      end
      default: sts_d = ST_OK;
    endcase
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | (cells_q[i] & {DATA_WIDTH{pos_c == CMP_W'(i)}});
    end
    data_d = rd_ok ? from_word(rd_word) : '0;
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (cells_q[i] == word) && (CNT_W'(i) < count_q);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + 1'b1;
    end else if (del_ok) begin
      count_d = count_q - 1'b1;
    end else if (command_i == CMD_CLEAR) begin
      count_d = '0;
    end
  end

  // shift cells up on insert, down on delete
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (ins_ok) begin
          if (pos_c == CMP_W'(i)) begin
            cells_q[i] <= word;
          end else if (i > 0 && pos_c < CMP_W'(i)) begin
            cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
          end
        end else if (del_ok) begin
          if (i < CAPACITY - 1 && pos_c <= CMP_W'(i)) begin
            cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.start) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      match_q <= match_d;
      op_q    <= command_i;
      sts_q   <= sts_d;
      data_q  <= data_d;
    end
  end

  // isolate the lowest match, then encode it
  assign low_bit = match_q & (~match_q + 1'b1);
  assign hit     = |match_q;

  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      first_idx[b] = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        if (((i >> b) & 1) == 1) first_idx[b] = first_idx[b] | low_bit[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      data_out_q  <= data_q;
      count_out_q <= OCNT_W'(count_q);
      if (op_q == CMD_LOCATE) begin
        status_q <= hit ? ST_OK : ST_NOTFOUND;
        found_q  <= hit ? OIDX_W'(first_idx) : '0;
      end else begin
        status_q <= sts_q;
        found_q  <= '0;
      end
    end
  end

  assign data_out_o    = signed'(data_out_q);
  assign found_index_o = found_q;
  assign status_o      = status_q;
  assign count_o       = count_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY)) else $error("count over capacity");
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && ins_ok |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow list");
  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && del_ok |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not shrink list");
  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> $countones(match_q) <= 32'($past(count_q)))
    else $error("match beyond count");

endmodule

FILE: src/positional_ordered_list.sv
// Positional ordered list: a bounded list of signed words with insert, delete
// and get by position, locate by value, and clear. Top level; depends on
// pol_pkg, pol_ctrl and pol_dp.
//
// Input channel: in_valid_i / in_stall_o with command_i, position_i, value_i.
// Output channel: out_valid_o / out_stall_i with data_out_o, found_index_o,
// status_o and count_o. A beat moves when valid is high and stall is low.
// Each input beat gives exactly one output beat.
// On acceptance, in the idle state, the command shifts the entry cells and
// runs the parallel compare against all 64 entries into registers; in the
// execute state the block encodes the first match and loads the output
// register once it is free. in_stall_o is high in the execute state, so a new
// command is not taken before the last one has loaded its result.
// The output register parts the two sides: a new command is taken while a
// result still waits. When the receiver stalls, the result holds and the
// next command waits in the execute state until the output register frees,
// so in_stall_o stays high.
// Reset clears the entry count and the output valid; entry contents stay
// undefined and are never read before they are written.
module positional_ordered_list import pol_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] data_out_o,
  output logic [OIDX_W-1:0]       found_index_o,
  output logic [STS_W-1:0]        status_o,
  output logic [OCNT_W-1:0]       count_o
);

  dp_cmd_t dp_cmd;

  pol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  pol_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .command_i     (command_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .data_out_o    (data_out_o),
    .found_index_o (found_index_o),
    .status_o      (status_o),
    .count_o       (count_o)
  );

endmodule

FILE: bench/pol_list_checker.sv
`timescale 1ns / 1ps
// Checker for positional_ordered_list: watches both channels, keeps its own list to
// predict every result beat and compares it field by field. Depends on pol_pkg.
module pol_list_checker import pol_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [VAL_W-1:0] data_out_i,
  input  logic [OIDX_W-1:0]       found_index_i,
  input  logic [STS_W-1:0]        status_i,
  input  logic [OCNT_W-1:0]       count_i,
  output int                      mismatches_o,
  output int                      pending_o,
  output int                      compared_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] data;
    logic [OIDX_W-1:0]       index;
    logic [STS_W-1:0]        status;
    logic [OCNT_W-1:0]       count;
  } list_result_t;

  word_t        list_words [CAPACITY];
  int unsigned  list_len;
  list_result_t expected_results [$];
  int           mismatches;
  int           pending;
  int           compared;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;
  assign compared_o   = compared;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: MISMATCH %s", $time, what);
  endtask

  task automatic predict_list_result(input logic [CMD_W-1:0] cmd,
                                     input logic [POS_W-1:0] pos,
                                     input logic signed [VAL_W-1:0] val,
                                     output list_result_t res);
    logic signed [63:0] wide;
    word_t              w;
    logic               hit;
    int                 i;
    wide       = val;
    w          = wide[DATA_WIDTH-1:0];
    res        = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (pos > list_len) begin
          res.status = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = w;
          list_len++;
        end
      end
      CMD_DELETE, CMD_GET: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          res.status = ST_BADPOS;
        end else begin
          wide     = $signed(list_words[pos]);
          res.data = wide[VAL_W-1:0];
          if (cmd == CMD_DELETE) begin
            for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
          end
        end
      end
      CMD_LOCATE: begin
        hit = 1'b0;
        for (i = 0; i < list_len; i++) begin
          if (!hit && list_words[i] == w) begin
            hit       = 1'b1;
            res.index = OIDX_W'(i);
          end
        end
        if (!hit) res.status = ST_NOTFOUND;
      end
      CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = OCNT_W'(list_len);
  endtask

  always @(posedge clk_i) begin : watch
    list_result_t want;
    list_result_t fresh;
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      // retire the older beat first: a result never belongs to a command taken this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = expected_results.pop_front();
          compared++;
          if (data_out_i !== want.data)
            report_mismatch($sformatf("data_out %0d, want %0d", data_out_i, want.data));
          if (found_index_i !== want.index)
            report_mismatch($sformatf("found_index %0d, want %0d", found_index_i, want.index));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_i, want.status));
          if (count_i !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", count_i, want.count));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_list_result(command_i, position_i, value_i, fresh);
        expected_results.push_back(fresh);
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for positional_ordered_list: directed and random command beats with
// random idling on both channels; checking lives in pol_list_checker. Depends on pol_pkg.
module tb;
  import pol_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;
  localparam int               POS_MAX     = (1 << POS_W) - 1;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_FILL, MIX_CHURN, MIX_ALL} mix_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        command_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] data_out_o;
  logic [OIDX_W-1:0]       found_index_o;
  logic [STS_W-1:0]        status_o;
  logic [OCNT_W-1:0]       count_o;

  int mismatches;
  int pending;
  int compared;
  int in_gap_pct;
  int out_stall_pct;
  int fill_level;
  int peak_level;
  int sent;
  int directed_sent;
  int spare_sent;
  int full_inserts;

  positional_ordered_list u_top (.*);

  pol_list_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .command_i,
    .position_i,
    .value_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .data_out_i    (data_out_o),
    .found_index_i (found_index_o),
    .status_i      (status_o),
    .count_i       (count_o),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .compared_o    (compared)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Timeout: results still outstanding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < out_stall_pct) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i  = cmd;
    position_i = pos;
    value_i    = val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    // track the list depth to steer positions
    case (cmd)
      CMD_INSERT: begin
        if (pos <= fill_level) begin
          if (fill_level < CAPACITY) fill_level++;
          else full_inserts++;
        end
      end
      CMD_DELETE: if (fill_level > 0 && pos < fill_level) fill_level--;
      CMD_CLEAR:  fill_level = 0;
      CMD_GET, CMD_LOCATE: ;
      default: spare_sent++;
    endcase
    if (fill_level > peak_level) peak_level = fill_level;
  endtask

  function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
    int last;
    last = (cmd == CMD_INSERT) ? fill_level : fill_level - 1;
    if (last > POS_MAX) last = POS_MAX;
    if (last < 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, POS_MAX));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return POS_W'(last);
      default: return POS_W'($urandom_range(0, last));
    endcase
  endfunction

  // small pool so that locates hit and duplicates appear
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 15) - 8;
      5, 6, 7:       return $urandom();
      8:             return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default:       return $urandom_range(0, 1) ? -1 : 0;
    endcase
  endfunction

  task automatic run_phase(input mix_e mix, input int beats, input int gap_pct,
                           input int stall_pct);
    int               r;
    int               w_ins;
    int               w_del;
    int               w_get;
    int               w_loc;
    logic [CMD_W-1:0] cmd;
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    case (mix)
      MIX_GROW:   begin w_ins = 60; w_del = 10; w_get = 15; w_loc = 15; end
      MIX_SHRINK: begin w_ins = 12; w_del = 55; w_get = 15; w_loc = 18; end
      MIX_FILL:   begin w_ins = 85; w_del = 3;  w_get = 6;  w_loc = 6;  end
      MIX_CHURN:  begin w_ins = 40; w_del = 40; w_get = 10; w_loc = 10; end
      default:    begin w_ins = 28; w_del = 25; w_get = 20; w_loc = 20; end
    endcase
    repeat (beats) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        cmd = CMD_SPARE_A + CMD_W'($urandom_range(0, 2));
      end else begin
        r = $urandom_range(0, 99);
        if (r < w_ins) cmd = CMD_INSERT;
        else if (r < w_ins + w_del) cmd = CMD_DELETE;
        else if (r < w_ins + w_del + w_get) cmd = CMD_GET;
        else if (r < w_ins + w_del + w_get + w_loc) cmd = CMD_LOCATE;
        else cmd = CMD_CLEAR;
      end
      send_command(cmd, pick_position(cmd), pick_value());
    end
  endtask

  initial begin : stimulus
    int guard;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_CLEAR;
    position_i    = '0;
    value_i       = '0;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    fill_level    = 0;
    peak_level    = 0;
    sent          = 0;
    spare_sent    = 0;
    full_inserts  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    in_gap_pct    = 20;
    out_stall_pct = 20;
    // empty list corner cases
    send_command(CMD_GET,    6'd0,  32'sd0);
    send_command(CMD_DELETE, 6'd5,  32'sd0);
    send_command(CMD_LOCATE, 6'd0,  32'sd0);
    send_command(CMD_CLEAR,  6'd0,  32'sd0);
    send_command(CMD_INSERT, 6'd1,  32'sd9);
    // build: -1, min, 0, max
    send_command(CMD_INSERT, 6'd0,  32'h8000_0000);
    send_command(CMD_INSERT, 6'd1,  32'h7fff_ffff);
    send_command(CMD_INSERT, 6'd0,  -32'sd1);
    send_command(CMD_INSERT, 6'd2,  32'sd0);
    send_command(CMD_INSERT, 6'd63, 32'sd3);
    send_command(CMD_GET,    6'd0,  32'sd0);
    send_command(CMD_GET,    6'd3,  32'sd0);
    send_command(CMD_GET,    6'd4,  32'sd0);
    send_command(CMD_GET,    6'd63, 32'sd0);
    send_command(CMD_LOCATE, 6'd0,  32'h7fff_ffff);
    send_command(CMD_LOCATE, 6'd0,  32'sd5);
    send_command(CMD_INSERT, 6'd2,  -32'sd1);
    send_command(CMD_LOCATE, 6'd63, -32'sd1);
    send_command(CMD_DELETE, 6'd0,  32'sd0);
    send_command(CMD_DELETE, 6'd3,  32'sd0);
    send_command(CMD_DELETE, 6'd4,  32'sd0);
    send_command(CMD_SPARE_A, 6'd0,  32'sd1);
    send_command(CMD_SPARE_B, 6'd63, 32'hffff_ffff);
    send_command(CMD_SPARE_C, 6'd21, 32'h5555_aaaa);
    send_command(CMD_CLEAR,  6'd42, 32'sd0);
    directed_sent = sent;

    run_phase(MIX_GROW,   220, 25, 25);
    run_phase(MIX_CHURN,  220, 0,  0);
    run_phase(MIX_SHRINK, 220, 30, 15);
    run_phase(MIX_FILL,   220, 15, 35);
    run_phase(MIX_CHURN,  220, 20, 20);
    run_phase(MIX_ALL,    220, 35, 35);
    run_phase(MIX_GROW,   220, 10, 40);
    run_phase(MIX_SHRINK, 220, 40, 10);
    run_phase(MIX_ALL,    140, 0,  0);
    in_valid_i = 1'b0;

    guard = 0;
    while (pending != 0 && guard < 200) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Sent %0d commands (%0d directed, %0d with unused codes), compared %0d results",
             sent, directed_sent, spare_sent, compared);
    $display("List depth peaked at %0d of %0d entries, %0d inserts hit a full list",
             peak_level, CAPACITY, full_inserts);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: positional_ordered_list.f
src/pol_pkg.sv
src/pol_ctrl.sv
src/pol_dp.sv
src/positional_ordered_list.sv
bench/pol_list_checker.sv
bench/tb.sv
